>>> hdl/spectral_min_magnitude_combine_defines.svh
// assertion macros used by the spectral min-magnitude combiner's queue
// no dependencies
`ifndef SPECTRAL_MIN_MAGNITUDE_COMBINE_DEFINES_SVH
`define SPECTRAL_MIN_MAGNITUDE_COMBINE_DEFINES_SVH

// condition must never hold outside reset
`define SMMC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SMMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hdl/smmc_pkg.sv
// constants shared by the spectral min-magnitude combiner
// no dependencies
package smmc_pkg;
	localparam int DEF_COMPONENT_WIDTH = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int QUOT_BITS = 32;
	localparam int ROOT_BITS = 16;
	localparam int FRAC_BITS = 16;
endpackage

>>> hdl/smmc_if.sv
// valid/ready channel interfaces for bin pairs in and combined bins out
// no dependencies
interface smmc_in_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] x_real;
	logic [W-1:0] x_imag;
	logic [W-1:0] y_real;
	logic [W-1:0] y_imag;
	modport source(output valid, x_real, x_imag, y_real, y_imag, input ready);
	modport sink(input valid, x_real, x_imag, y_real, y_imag, output ready);
endinterface

interface smmc_out_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] out_real;
	logic [W-1:0] out_imag;
	modport source(output valid, out_real, out_imag, input ready);
	modport sink(input valid, out_real, out_imag, output ready);
endinterface

>>> hdl/spectral_min_magnitude_combine.sv
// top level of the spectral min-magnitude combiner
// depends on smmc_pkg, smmc_if, smmc_front, smmc_fifo, smmc_back
// Takes one bin pair per cycle and returns one bin per cycle, in order, when not stalled.
// The front registers magnitudes, then squares, then norms and compare; the queue
// follows, then 32 divider stages, 16 square-root stages, one scaling multiply
// stage and the output register.
// The front and back stall independently, decoupled by a four-entry queue.
module spectral_min_magnitude_combine #(
	parameter int COMPONENT_WIDTH = smmc_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	smmc_in_if.sink    in,
	smmc_out_if.source out
);
	localparam int DW = 6 * COMPONENT_WIDTH + 1;

	logic          push, q_ready, pop, q_valid;
	logic [DW-1:0] wdata, rdata;

	smmc_front #(.W(COMPONENT_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in(in),
		.push(push), .q_ready(q_ready), .push_data(wdata)
	);

	smmc_fifo #(.DW(DW), .DEPTH(smmc_pkg::FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wdata), .ready(q_ready),
		.pop(pop), .nonempty(q_valid), .rdata(rdata)
	);

	smmc_back #(.W(COMPONENT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(rdata),
		.pop(pop), .out(out)
	);
endmodule

>>> hdl/smmc_front.sv
// front part: magnitudes, squared norms and pass-through classification
// depends on smmc_pkg, smmc_in_if
module smmc_front #(
	parameter int W = smmc_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	smmc_in_if.sink        in,
	output logic           push,
	input  logic           q_ready,
	output logic [6*W:0]   push_data
);
	logic         en;
	logic         v_s1, v_s2, v_s3;
	logic [W-1:0] xr_s1, xi_s1, xrm_s1, xim_s1, yrm_s1, yim_s1;
	logic [W-1:0] xr_s2, xi_s2, xr_s3, xi_s3;
	logic [2*W-1:0] xrr_s2, xii_s2, yrr_s2, yii_s2;
	logic [2*W-1:0] x2_s3, y2_s3;
	logic         pass_s3;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		mag = v[W-1] ? (~v + W'(1)) : v;
	endfunction

	assign en = !v_s3 || q_ready;
	assign in.ready = en;
	assign push = v_s3 && q_ready;
	assign push_data = {pass_s3, x2_s3, y2_s3, xr_s3, xi_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xr_s1  <= in.x_real;
			xi_s1  <= in.x_imag;
			xrm_s1 <= mag(in.x_real);
			xim_s1 <= mag(in.x_imag);
			yrm_s1 <= mag(in.y_real);
			yim_s1 <= mag(in.y_imag);
			xr_s2  <= xr_s1;
			xi_s2  <= xi_s1;
			xrr_s2 <= xrm_s1 * xrm_s1;
			xii_s2 <= xim_s1 * xim_s1;
			yrr_s2 <= yrm_s1 * yrm_s1;
			yii_s2 <= yim_s1 * yim_s1;
			xr_s3  <= xr_s2;
			xi_s3  <= xi_s2;
			x2_s3  <= xrr_s2 + xii_s2;
			y2_s3  <= yrr_s2 + yii_s2;
			pass_s3 <= ((xrr_s2 + xii_s2) == '0) || ((yrr_s2 + yii_s2) >= (xrr_s2 + xii_s2));
		end
	end
endmodule

>>> hdl/smmc_fifo.sv
// short queue between the front and back parts
// depends on smmc_pkg, spectral_min_magnitude_combine_defines.svh
`include "spectral_min_magnitude_combine_defines.svh"
module smmc_fifo #(
	parameter int DW = 8,
	parameter int DEPTH = smmc_pkg::FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          ready,
	input  logic          pop,
	output logic          nonempty,
	output logic [DW-1:0] rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign ready = cnt_q != CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata = mem_q[rd_q];

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		nxt = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop) rd_q <= nxt(rd_q);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	`SMMC_ASSERT_NEVER(a_overflow, clk, arst_n, push && !ready, "transfer into full queue")
	`SMMC_ASSERT_NEVER(a_underflow, clk, arst_n, pop && !nonempty, "pop from empty queue")
	`SMMC_ASSERT_IMPL(a_count, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "queue count out of range")
endmodule

>>> hdl/smmc_back.sv
// back part: restoring divider, square-root pipeline and component scaling
// depends on smmc_pkg, smmc_out_if
module smmc_back #(
	parameter int W = smmc_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  logic [6*W:0] q_data,
	output logic         pop,
	smmc_out_if.source   out
);
	localparam int QB = smmc_pkg::QUOT_BITS;
	localparam int RB = smmc_pkg::ROOT_BITS;
	localparam int FB = smmc_pkg::FRAC_BITS;
	localparam int NS = QB + RB;

	logic adv;
	// per stage payload, index 0 is the queue head
	logic            v_s   [NS+1];
	logic            pass_s[NS+1];
	logic [2*W-1:0]  x2_s  [QB+1];
	logic [2*W:0]    rem_s [QB+1];
	logic [QB-1:0]   quo_s [NS+1];
	logic [RB-1:0]   f_s   [NS+1];
	logic [W-1:0]    xr_s  [NS+1];
	logic [W-1:0]    xi_s  [NS+1];
	logic            v_m_q, pass_m_q, nr_m_q, ni_m_q;
	logic [W-1:0]    xr_m_q, xi_m_q, mr_m_q, mi_m_q;
	logic [RB-1:0]   f_m_q;
	logic [W+RB-1:0] pr, pi;
	logic            v_o_q;
	logic [W-1:0]    or_o_q, oi_o_q;

	assign adv = !v_o_q || out.ready;
	assign pop = adv && q_valid;
	assign v_s[0] = q_valid;
	assign pass_s[0] = q_data[6*W];
	assign x2_s[0] = q_data[6*W-1:4*W];
	assign rem_s[0] = {1'b0, q_data[4*W-1:2*W]};
	assign quo_s[0] = '0;
	assign f_s[0] = '0;
	assign xr_s[0] = q_data[2*W-1:W];
	assign xi_s[0] = q_data[W-1:0];

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s[k+1] <= 1'b0;
				else if (adv) v_s[k+1] <= v_s[k];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					pass_s[k+1] <= pass_s[k];
					xr_s[k+1] <= xr_s[k];
					xi_s[k+1] <= xi_s[k];
				end
			end
			if (k < QB) begin : g_div
				logic [2*W:0] sh;
				logic         ge;
				assign sh = {rem_s[k][2*W-1:0], 1'b0};
				assign ge = sh >= {1'b0, x2_s[k]};
				always_ff @(posedge clk) begin
					if (adv) begin
						x2_s[k+1]  <= x2_s[k];
						rem_s[k+1] <= ge ? sh - {1'b0, x2_s[k]} : sh;
						quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
						f_s[k+1]   <= '0;
					end
				end
			end else begin : g_root
				logic [RB-1:0]   t;
				logic [2*RB-1:0] tt;
				assign t = f_s[k] | (RB'(1) << (NS - 1 - k));
				assign tt = t * t;
				always_ff @(posedge clk) begin
					if (adv) begin
						quo_s[k+1] <= quo_s[k];
						f_s[k+1]   <= (QB'(tt) <= quo_s[k]) ? t : f_s[k];
					end
				end
			end
		end
	endgenerate

	assign pr = mr_m_q * f_m_q;
	assign pi = mi_m_q * f_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m_q <= 1'b0;
			v_o_q <= 1'b0;
		end else if (adv) begin
			v_m_q <= v_s[NS];
			v_o_q <= v_m_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_m_q <= pass_s[NS];
			xr_m_q <= xr_s[NS];
			xi_m_q <= xi_s[NS];
			nr_m_q <= xr_s[NS][W-1];
			ni_m_q <= xi_s[NS][W-1];
			mr_m_q <= xr_s[NS][W-1] ? (~xr_s[NS] + W'(1)) : xr_s[NS];
			mi_m_q <= xi_s[NS][W-1] ? (~xi_s[NS] + W'(1)) : xi_s[NS];
			f_m_q <= f_s[NS];
			if (pass_m_q) begin
				or_o_q <= xr_m_q;
				oi_o_q <= xi_m_q;
			end else begin
				or_o_q <= nr_m_q ? (~pr[W+FB-1:FB] + W'(1)) : pr[W+FB-1:FB];
				oi_o_q <= ni_m_q ? (~pi[W+FB-1:FB] + W'(1)) : pi[W+FB-1:FB];
			end
		end
	end

	assign out.valid = v_o_q;
	assign out.out_real = or_o_q;
	assign out.out_imag = oi_o_q;
endmodule

>>> tb/testbench.sv
// self-checking testbench for spectral_min_magnitude_combine
// depends on smmc_pkg, smmc_in_if, smmc_out_if and the block's rtl
`timescale 1ns / 1ps

module testbench;
	localparam int CW = smmc_pkg::DEF_COMPONENT_WIDTH;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] MAX_NEG = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [CW-1:0] re;
		logic [CW-1:0] im;
	} bin_t;

	logic clk;
	logic arst_n;
	smmc_in_if  #(.W(CW)) bin_in();
	smmc_out_if #(.W(CW)) bin_out();

	bin_t combined_q[$];
	int   errors;
	int   cycles;
	int   tx_idle_pct;
	int   rx_stall_pct;
	int   rx_hold_cycles;

	spectral_min_magnitude_combine #(.COMPONENT_WIDTH(CW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in(bin_in),
		.out(bin_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CW:0] abs_val(logic [CW-1:0] v);
		logic [CW:0] e;
		e = {v[CW-1], v};
		return v[CW-1] ? -e : e;
	endfunction

	function automatic logic [CW-1:0] apply_gain(logic [CW-1:0] c, logic [15:0] gain);
		logic [127:0] s;
		s = (128'(abs_val(c)) * 128'(gain)) >> smmc_pkg::FRAC_BITS;
		return c[CW-1] ? CW'(-s) : CW'(s);
	endfunction

	// keep phase of x, magnitude of the smaller one
	function automatic bin_t min_magnitude_bin(logic [CW-1:0] xr, xi, yr, yi);
		logic [127:0] x2, y2, q, t;
		logic [15:0]  gain;
		bin_t r;
		x2 = 128'(abs_val(xr)) * 128'(abs_val(xr)) + 128'(abs_val(xi)) * 128'(abs_val(xi));
		y2 = 128'(abs_val(yr)) * 128'(abs_val(yr)) + 128'(abs_val(yi)) * 128'(abs_val(yi));
		if (x2 == 0 || y2 >= x2) begin
			r.re = xr;
			r.im = xi;
			return r;
		end
		q = (y2 << smmc_pkg::QUOT_BITS) / x2;
		gain = '0;
		for (int b = smmc_pkg::ROOT_BITS - 1; b >= 0; b--) begin
			t = 128'(gain | (16'd1 << b));
			if (t * t <= q)
				gain = 16'(t);
		end
		r.re = apply_gain(xr, gain);
		r.im = apply_gain(xi, gain);
		return r;
	endfunction

	// receiver ready, with a counted long hold when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_out.ready <= 1'b0;
		end else if (rx_hold_cycles > 0) begin
			bin_out.ready <= 1'b0;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			bin_out.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// signals are stable at the falling edge; the transfer happens at the next rise
	always @(negedge clk) begin
		bin_t got, want;
		if (arst_n && bin_out.valid && bin_out.ready) begin
			got.re = bin_out.out_real;
			got.im = bin_out.out_imag;
			if (combined_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected bin re=%h im=%h", $time, got.re, got.im);
			end else begin
				want = combined_q.pop_front();
				if (got.re !== want.re) begin
					errors++;
					$display("%0t: out_real expected %h actual %h", $time, want.re, got.re);
				end
				if (got.im !== want.im) begin
					errors++;
					$display("%0t: out_imag expected %h actual %h", $time, want.im, got.im);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_bin(logic [CW-1:0] xr, xi, yr, yi);
		logic took;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			bin_in.valid <= 1'b0;
			@(posedge clk);
		end
		bin_in.valid  <= 1'b1;
		bin_in.x_real <= xr;
		bin_in.x_imag <= xi;
		bin_in.y_real <= yr;
		bin_in.y_imag <= yi;
		do begin
			@(negedge clk);
			took = bin_in.ready;
			@(posedge clk);
		end while (!took);
		combined_q.push_back(min_magnitude_bin(xr, xi, yr, yi));
	endtask

	task automatic stop_sending();
		bin_in.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (combined_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_bins();
		send_bin('0, '0, '0, '0);
		send_bin('0, '0, MAX_NEG, MAX_NEG);
		send_bin(MAX_NEG, MAX_NEG, '0, '0);
		send_bin(MAX_NEG, '0, '0, 32'd1);
		send_bin(MAX_NEG, MAX_NEG, MAX_POS, MAX_POS);
		send_bin(MAX_POS, MAX_NEG, MAX_NEG, MAX_POS);
		send_bin(MAX_POS, MAX_POS, MAX_POS, MAX_POS - 1);
		send_bin(32'd1, '0, '0, '0);
		send_bin(-32'sd1, -32'sd1, '0, 32'd1);
		send_bin(32'd3, 32'd4, 32'd5, '0);
		send_bin(32'd3, 32'd4, 32'd4, 32'd3);
		send_bin(32'd3, 32'd4, 32'd4, 32'd2);
		send_bin(-32'sd3, 32'd4, 32'd1, 32'd1);
		send_bin(32'h0001_0000, '0, '0, 32'h0000_8000);
		send_bin(-32'sh0001_0000, 32'h0001_0000, 32'h0000_0001, '0);
		send_bin(MAX_POS, '0, 32'd1, '0);
		send_bin(MAX_NEG, MAX_POS, 32'h7fff_0000, 32'h0001_0000);
		send_bin(32'hdead_beef, 32'h1234_5678, 32'h0bad_f00d, -32'sh0555_5555);
		send_bin('0, 32'd7, '0, -32'sd6);
		send_bin(32'd100, -32'sd100, -32'sd99, 32'd100);
	endtask

	function automatic logic [CW-1:0] pick_edge_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return MAX_POS;
			4: return MAX_NEG;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_bins(int count);
		logic [CW-1:0] xr, xi, yr, yi;
		int d;
		repeat (count) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					xr = $urandom; xi = $urandom; yr = $urandom; yi = $urandom;
				end
				8, 9, 10, 11: begin
					xr = $signed($urandom_range(0, 8191)) - 4096;
					xi = $signed($urandom_range(0, 8191)) - 4096;
					yr = $signed($urandom_range(0, 8191)) - 4096;
					yi = $signed($urandom_range(0, 8191)) - 4096;
				end
				12, 13, 14, 15, 16: begin
					// nearly equal magnitudes, y rotated against x
					xr = $urandom; xi = $urandom;
					d = $signed($urandom_range(0, 6)) - 3;
					yr = xi + d;
					yi = ($urandom_range(0, 1)) ? xr : -xr;
				end
				default: begin
					xr = pick_edge_value(); xi = pick_edge_value();
					yr = pick_edge_value(); yi = pick_edge_value();
				end
			endcase
			send_bin(xr, xi, yr, yi);
		end
		stop_sending();
	endtask

	// receiver holds off long enough to fill the queue and stall the input
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		@(posedge clk);
		rx_hold_cycles <= 300;
		test_random_bins(120);
		wait_drained();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_cycles = 0;
		arst_n = 1'b0;
		bin_in.valid = 1'b0;
		bin_in.x_real = '0;
		bin_in.x_imag = '0;
		bin_in.y_real = '0;
		bin_in.y_imag = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_bins();
		stop_sending();
		wait_drained();

		tx_idle_pct = 37;
		rx_stall_pct = 69;
		test_random_bins(550);
		wait_drained();

		tx_idle_pct = 69;
		rx_stall_pct = 37;
		test_random_bins(550);

		test_output_backpressure();

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		test_random_bins(650);

		wait_drained();
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

>>> sim.f
+incdir+hdl
hdl/smmc_pkg.sv
hdl/smmc_if.sv
hdl/smmc_front.sv
hdl/smmc_fifo.sv
hdl/smmc_back.sv
hdl/spectral_min_magnitude_combine.sv
tb/testbench.sv
